// ===== rtl/core/cbts_pkg.sv =====
// cbts_pkg: shared types and constants of the can bit-timing search
// no dependencies
`default_nettype none
package cbts_pkg;
  localparam int unsigned MaxPrescaler = 1024;
  localparam int unsigned PW = $clog2(MaxPrescaler + 1);
  localparam int unsigned MinTq = 8;
  localparam int unsigned MaxTq = 25;
  localparam int unsigned MaxSeg1 = 16;
  localparam int unsigned MaxSjw = 4;
  localparam int unsigned AccInv = 1000;
  localparam int unsigned NumW = 34;   // 2*clock fits in 33 bits
  localparam int unsigned DenW = 32;   // p*rate*2 < 2^31

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRY, ST_DIV, ST_CHECK, ST_SEG, ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] clock_hz;
    logic [9:0]  rate_khz;
    logic [3:0]  jump_width;
    logic [6:0]  sample_percent;
  } req_t;

  typedef struct packed {
    logic [25:0] timing_word;
    logic        found;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/cbts_if.sv =====
// cbts_if: valid/ready channels carrying the request and response payloads
// depends on cbts_pkg for payload types
`default_nettype none
interface cbts_req_if;
  logic valid;
  logic ready;
  cbts_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbts_rsp_if;
  logic valid;
  logic ready;
  cbts_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/can_bit_timing_search.sv =====
// can_bit_timing_search: top level of the can bit-timing search
// depends on cbts_pkg, cbts_if, cbts_div
//
// usage: one request on req (clock in hz, bitrate in khz, jump width, sample
// point percent) gives one response on rsp (timing word, found flag).
// prescalers 1..1024 are tried in order; each try runs a serial division of
// 2*clock+p*rate by 2*p*rate in the single divider, then an accuracy check
// when the count is in range and a segment step when that check passes.
// a zero bitrate is answered without any trial; a new request is taken in the
// cycle after the response has left.
// req.ready is high only while idle; one request is worked at a time.
// the response waits in an output register until rsp.ready is high, and no
// new request is taken until it has been delivered.
// reset returns the sequencer to idle and drops rsp.valid.
`default_nettype none
module can_bit_timing_search (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cbts_req_if.sink   req,
  cbts_rsp_if.source rsp
);
  import cbts_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic [PW-1:0]  p_q, p_d;
  logic [DenW-1:0] pb_q, pb_d;      // p*rate
  logic [DenW-1:0] rate;
  logic [NumW-1:0] quo;
  logic [4:0]  r_q, r_d;
  logic [2:0]  sjw;
  rsp_t out_q, out_d;
  logic div_done;
  logic restart_q;
  logic [NumW-1:0] num;
  // accuracy check
  logic [41:0] prod, diff;
  logic [51:0] diff_k;
  // segment math
  logic [12:0] segnum;
  logic [5:0]  s1p;      // seg1+1
  logic signed [7:0] seg1, seg2;
  logic ok;

  assign rate = DenW'(req_q.rate_khz) * DenW'(AccInv);
  assign num = {1'b0, req_q.clock_hz, 1'b0} + NumW'(pb_q);

  // the divider is kicked in the cycle in which pb first holds its loaded or moved-on value
  cbts_div u_div (
    .clk_i, .rst_ni,
    .start_i(restart_q),
    .num_i(num),
    .den_i({pb_q[DenW-2:0], 1'b0}),
    .done_o(div_done),
    .quo_o(quo)
  );

  always_comb begin
    sjw = (req_q.jump_width > 4'(MaxSjw)) ? 3'(MaxSjw)
        : (req_q.jump_width == 4'd0) ? 3'd1 : req_q.jump_width[2:0];
    prod = 42'(r_q) * 42'(pb_q);
    diff = (prod >= 42'(req_q.clock_hz)) ? prod - 42'(req_q.clock_hz)
                                         : 42'(req_q.clock_hz) - prod;
    diff_k = 52'(diff) * 52'(AccInv);
    // r*sp/100 rounded half up, via (2*r*sp+100)/200 with a small reciprocal
    segnum = 13'(r_q) * 13'(req_q.sample_percent);
    s1p = 6'(((32'(segnum) * 2 + 100) * 32'd20972) >> 22);
    seg1 = 8'(s1p) - 8'sd1;
    seg2 = 8'(r_q) - 8'sd1 - seg1;
    ok = (7'(s1p) * 2 >= 7'(r_q)) && (seg1 <= 8'(MaxSeg1)) && (seg2 >= 8'sd1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req.valid) state_d = ST_TRY;
      ST_TRY: state_d = (rate == '0) ? ST_OUT : ST_DIV;
      ST_DIV: if (div_done) begin
        if (quo < NumW'(MinTq)) state_d = ST_OUT;
        else if (quo > NumW'(MaxTq)) state_d = (p_q == PW'(MaxPrescaler)) ? ST_OUT : ST_DIV;
        else state_d = ST_CHECK;
      end
      ST_CHECK: if (diff_k >= 52'(pb_q))
        state_d = (p_q == PW'(MaxPrescaler)) ? ST_OUT : ST_DIV;
        else state_d = ST_SEG;
      ST_SEG: state_d = (ok || p_q == PW'(MaxPrescaler)) ? ST_OUT : ST_DIV;
      ST_OUT: if (rsp.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    p_d = p_q;
    pb_d = pb_q;
    r_d = r_q;
    out_d = out_q;
    case (state_q)
      ST_IDLE: out_d = '0;
      ST_TRY: begin
        p_d = PW'(1);
        pb_d = rate;
      end
      ST_DIV: if (div_done) begin
        r_d = 5'(quo);
        if (quo > NumW'(MaxTq) && p_q != PW'(MaxPrescaler)) begin
          p_d = p_q + 1'b1;
          pb_d = pb_q + rate;
        end
      end
      ST_CHECK: if (diff_k >= 52'(pb_q) && p_q != PW'(MaxPrescaler)) begin
        p_d = p_q + 1'b1;
        pb_d = pb_q + rate;
      end
      ST_SEG: if (ok) begin
        out_d.found = 1'b1;
        out_d.timing_word = {2'(sjw - 3'd1), 4'(seg2 - 8'sd1), 4'(seg1 - 8'sd1),
                             6'd0, 10'(p_q - 1'b1)};
      end else if (p_q != PW'(MaxPrescaler)) begin
        p_d = p_q + 1'b1;
        pb_d = pb_q + rate;
      end
      default: ;
    endcase
  end

  // register the state, and restart the divider whenever a new prescaler is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      restart_q <= 1'b0;
    end else begin
      state_q <= state_d;
      restart_q <= (state_d == ST_DIV) && (state_q != ST_DIV || div_done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req.valid) req_q <= req.data;
    p_q <= p_d;
    pb_q <= pb_d;
    r_q <= r_d;
    out_q <= out_d;
  end

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = (state_q == ST_OUT);
  assign rsp.data = out_q;
endmodule
`default_nettype wire

// ===== rtl/core/cbts_div.sv =====
// cbts_div: radix-2 restoring divider, one quotient bit per cycle
// depends on cbts_pkg
`default_nettype none
module cbts_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [cbts_pkg::NumW-1:0] num_i,
  input  wire logic [cbts_pkg::DenW-1:0] den_i,
  output logic done_o,
  output logic [cbts_pkg::NumW-1:0] quo_o
);
  import cbts_pkg::*;
  localparam int unsigned CW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = CW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o = quo_d;
endmodule
`default_nettype wire
